FILE: rtl/core/chacha_pkg.sv
// ----------------------------------------------------------------------------
// chacha_pkg
// Types, constants and the quarter-round function shared by the cipher core.
// ----------------------------------------------------------------------------
package chacha_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [15:0] block_t;

	// State word constants "expand 32-byte k"
	localparam word_t SIGMA_0 = 32'h6170_7865;
	localparam word_t SIGMA_1 = 32'h3320_646E;
	localparam word_t SIGMA_2 = 32'h7962_2D32;
	localparam word_t SIGMA_3 = 32'h6B20_6574;

	// Ten double rounds, one round per cycle
	localparam int unsigned NUM_ROUNDS = 20;
	localparam int unsigned ROUND_W    = $clog2(NUM_ROUNDS);
	localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

	// Configuration register indexes
	localparam int unsigned CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_01 = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_23 = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_45 = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_67 = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_NONCE  = 3'd4;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic in_load;   // capture input word
		logic x_load;    // load working state from input state
		logic round_en;  // run one round
		logic finalize;  // add input state back, bump counter
		logic emit;      // write result word to output register
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_block;  // word at the input needs a fresh block
		logic round_done;  // last round in progress
		logic out_free;    // output register can take a word
	} dp_status_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} qr_t;

	// One quarter round, rotations by 16, 12, 8 and 7
	function automatic qr_t quarter_round(input word_t a_i, input word_t b_i,
	                                      input word_t c_i, input word_t d_i);
		word_t a;
		word_t b;
		word_t c;
		word_t d;
		word_t t;
		qr_t   r;
		a = a_i;
		b = b_i;
		c = c_i;
		d = d_i;
		a = a + b; t = d ^ a; d = {t[15:0], t[31:16]};
		c = c + d; t = b ^ c; b = {t[19:0], t[31:20]};
		a = a + b; t = d ^ a; d = {t[23:0], t[31:24]};
		c = c + d; t = b ^ c; b = {t[24:0], t[31:25]};
		r.a = a;
		r.b = b;
		r.c = c;
		r.d = d;
		return r;
	endfunction

endpackage

FILE: rtl/core/chacha_ctrl.sv
// ----------------------------------------------------------------------------
// chacha_ctrl
// Sequencer: input capture, block generation and result hand-off.
// ----------------------------------------------------------------------------
module chacha_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  chacha_pkg::dp_status_t status,
	output chacha_pkg::dp_cmd_t    cmd
);
	import chacha_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = status.need_block ? ST_LOAD : ST_EMIT;
				end
			end
			ST_LOAD:  state_nxt = ST_ROUND;
			ST_ROUND: begin
				if (status.round_done) state_nxt = ST_FINAL;
			end
			ST_FINAL: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.in_load = in_valid;
			end
			ST_LOAD:  cmd.x_load   = 1'b1;
			ST_ROUND: cmd.round_en = 1'b1;
			ST_FINAL: cmd.finalize = 1'b1;
			ST_EMIT:  cmd.emit     = status.out_free;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/chacha_datapath.sv
// ----------------------------------------------------------------------------
// chacha_datapath
// Key registers, block counter, round unit, keystream store and output word.
// ----------------------------------------------------------------------------
module chacha_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [chacha_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [63:0]                          cfg_wdata,
	input  logic [31:0]                          data_in,
	input  logic [2:0]                           byte_count,
	input  logic                                 end_of_call,
	input  logic                                 restart,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [31:0]                          data_out,
	output logic [2:0]                           out_count,
	output logic                                 out_last,
	input  chacha_pkg::dp_cmd_t                  cmd,
	output chacha_pkg::dp_status_t               status
);
	import chacha_pkg::*;

	logic [63:0]        key01_q;
	logic [63:0]        key23_q;
	logic [63:0]        key45_q;
	logic [63:0]        key67_q;
	logic [63:0]        nonce_q;
	logic [63:0]        ctr_q;
	logic               ks_ready_q;
	logic [3:0]         pos_q;
	logic [ROUND_W-1:0] round_q;
	block_t             x_q;
	block_t             init_s;
	block_t             round_nxt;
	logic [31:0]        data_q;
	logic [2:0]         cnt_q;
	logic               last_q;
	logic               out_valid_q;
	logic [31:0]        data_out_q;
	logic [2:0]         out_count_q;
	logic               out_last_q;
	logic [2:0]         cnt_norm;
	logic [31:0]        byte_mask;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0;
			key23_q <= '0;
			key45_q <= '0;
			key67_q <= '0;
			nonce_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_KEY_01: key01_q <= cfg_wdata;
				REG_KEY_23: key23_q <= cfg_wdata;
				REG_KEY_45: key45_q <= cfg_wdata;
				REG_KEY_67: key67_q <= cfg_wdata;
				REG_NONCE:  nonce_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input state of the block
	always_comb begin
		init_s[0]  = SIGMA_0;
		init_s[1]  = SIGMA_1;
		init_s[2]  = SIGMA_2;
		init_s[3]  = SIGMA_3;
		init_s[4]  = key01_q[31:0];
		init_s[5]  = key01_q[63:32];
		init_s[6]  = key23_q[31:0];
		init_s[7]  = key23_q[63:32];
		init_s[8]  = key45_q[31:0];
		init_s[9]  = key45_q[63:32];
		init_s[10] = key67_q[31:0];
		init_s[11] = key67_q[63:32];
		init_s[12] = ctr_q[31:0];
		init_s[13] = ctr_q[63:32];
		init_s[14] = nonce_q[31:0];
		init_s[15] = nonce_q[63:32];
	end

	// Round unit: four quarter rounds, column on even rounds, diagonal on odd
	always_comb begin
		qr_t r;
		round_nxt = x_q;
		for (int i = 0; i < 4; i++) begin
			if (!round_q[0]) begin
				r = quarter_round(x_q[i], x_q[4 + i], x_q[8 + i], x_q[12 + i]);
				round_nxt[i]      = r.a;
				round_nxt[4 + i]  = r.b;
				round_nxt[8 + i]  = r.c;
				round_nxt[12 + i] = r.d;
			end else begin
				r = quarter_round(x_q[i], x_q[4 + ((i + 1) % 4)],
				                  x_q[8 + ((i + 2) % 4)], x_q[12 + ((i + 3) % 4)]);
				round_nxt[i]                  = r.a;
				round_nxt[4 + ((i + 1) % 4)]  = r.b;
				round_nxt[8 + ((i + 2) % 4)]  = r.c;
				round_nxt[12 + ((i + 3) % 4)] = r.d;
			end
		end
	end

	// Working state, which becomes the keystream store after the final add
	always_ff @(posedge clk) begin
		if (cmd.x_load) begin
			x_q <= init_s;
		end else if (cmd.round_en) begin
			x_q <= round_nxt;
		end else if (cmd.finalize) begin
			for (int i = 0; i < 16; i++) begin
				x_q[i] <= x_q[i] + init_s[i];
			end
		end
	end

	// Round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (cmd.x_load) begin
			round_q <= '0;
		end else if (cmd.round_en) begin
			round_q <= round_q + 1'b1;
		end
	end

	// Block counter, keystream valid flag and word position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q      <= '0;
			ks_ready_q <= 1'b0;
			pos_q      <= '0;
		end else if (cmd.in_load && restart) begin
			ctr_q      <= '0;
			ks_ready_q <= 1'b0;
			pos_q      <= '0;
		end else if (cmd.finalize) begin
			ctr_q      <= ctr_q + 64'd1;
			ks_ready_q <= 1'b1;
			pos_q      <= '0;
		end else if (cmd.emit) begin
			if (pos_q == 4'd15 || last_q) begin
				ks_ready_q <= 1'b0;
				pos_q      <= '0;
			end else begin
				pos_q <= pos_q + 4'd1;
			end
		end
	end

	// Input word register
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			data_q <= data_in;
			cnt_q  <= byte_count;
			last_q <= end_of_call;
		end
	end

	// Byte count clamp and mask; out-of-range counts mean a full word
	always_comb begin
		cnt_norm = (cnt_q == 3'd0 || cnt_q > 3'd4) ? 3'd4 : cnt_q;
		case (cnt_norm)
			3'd1:    byte_mask = 32'h0000_00FF;
			3'd2:    byte_mask = 32'h0000_FFFF;
			3'd3:    byte_mask = 32'h00FF_FFFF;
			default: byte_mask = 32'hFFFF_FFFF;
		endcase
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_out_q  <= (data_q ^ x_q[pos_q]) & byte_mask;
			out_count_q <= cnt_norm;
			out_last_q  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign out_count = out_count_q;
	assign out_last  = out_last_q;

	// Status
	assign status.need_block = restart || !ks_ready_q;
	assign status.round_done = (round_q == LAST_ROUND);
	assign status.out_free   = !out_valid_q || out_ready;

endmodule

FILE: rtl/core/chacha20_stream_cipher.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher
// ChaCha20 (20 rounds, 64-bit nonce, 64-bit block counter) word encryptor.
// A word whose keystream block is already held is accepted and then XORed
// with its keystream word into the output register once that register is
// free. A word that opens a new block (first word after reset, after an
// end-of-call word, after sixteen words, or with restart set) first passes
// through the input-state load, the rounds through a unit of four parallel
// quarter rounds doing one round per cycle, and the final add and counter
// increment. The next word is accepted while a finished result still waits
// in the output register. Key and nonce registers are read both at the
// input-state load and at the final add.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [chacha_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [63:0]                       cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [31:0]                       data_in,
	input  logic [2:0]                        byte_count,
	input  logic                              end_of_call,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [31:0]                       data_out,
	output logic [2:0]                        out_count,
	output logic                              out_last
);
	import chacha_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencer
	chacha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath
	chacha_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.data_in     (data_in),
		.byte_count  (byte_count),
		.end_of_call (end_of_call),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.data_out    (data_out),
		.out_count   (out_count),
		.out_last    (out_last),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

FILE: rtl/core/chacha_checker.sv
// ----------------------------------------------------------------------------
// chacha_checker
// Port-level checks on the cipher core, bound to the top level.
// ----------------------------------------------------------------------------
module chacha_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] data_out,
	input logic [2:0]  out_count,
	input logic        out_last
);

	// Stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(data_out)
			&& $stable(out_count) && $stable(out_last))
		else $error("result word changed while stalled");

	// Result byte count always clamped to 1..4
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_count == 3'd1 || out_count == 3'd2
			|| out_count == 3'd3 || out_count == 3'd4))
		else $error("result byte count out of range");

	// Bytes beyond the count are zero
	a_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !((out_count == 3'd1 && data_out[31:8] != 24'd0)
			|| (out_count == 3'd2 && data_out[31:16] != 16'd0)
			|| (out_count == 3'd3 && data_out[31:24] != 8'd0)))
		else $error("result bytes beyond count not zero");

	// One word in work at a time: ready drops after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a word is in work");

endmodule

bind chacha20_stream_cipher chacha_checker u_chacha_checker (.*);
